>>> hdl/dmxm_pkg.sv
// shared types, constants and field widths for the dmx layer merge block
package dmxm_pkg;

    localparam int CH_W = 9;
    localparam int LVL_W = 8;
    localparam int UNI_W = 15;
    localparam int MS_W = 20;
    localparam int AGE_W = 16;
    localparam int MODE_W = 2;
    localparam int NET_W = 7;
    localparam int SUB_W = 4;
    localparam int UNIN_W = 4;
    localparam int KIND_W = 3;
    localparam int ADDR_W = 5;
    localparam int REG_W = 32;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 24;
    localparam int PROD_W = LVL_W + MS_W;

    localparam int DEFAULT_CHANNEL_COUNT = 512;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    localparam logic [AGE_W-1:0] DEFAULT_TIMEOUT = 16'd3000;
    localparam logic [MS_W-1:0] DEFAULT_FADE_LENGTH = 20'd1000;
    localparam logic [MS_W-1:0] ELAPSED_MAX = 20'hFFFFF;
    localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;
    localparam logic [3:0] BLEND_LAST_STEP = 4'd9;

    // merge modes
    localparam logic [MODE_W-1:0] MODE_LOCAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NET_HOLD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HTP = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MERGE_MODE = 3'd0;
    localparam logic [2:0] REG_NET = 3'd1;
    localparam logic [2:0] REG_SUBNET = 3'd2;
    localparam logic [2:0] REG_UNIVERSE = 3'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;
    localparam logic [ADDR_W-1:0] ADDR_MERGE_MODE = 5'd0;

    typedef enum logic [KIND_W-1:0] {
        K_TICK   = 3'd0,
        K_LOCAL  = 3'd1,
        K_NET    = 3'd2,
        K_FILL   = 3'd3,
        K_TARGET = 3'd4,
        K_FADE   = 3'd5,
        K_READ   = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CH_W-1:0]   channel;
        logic [LVL_W-1:0]  level;
        logic              last;
        logic [MS_W-1:0]   fade_ms;
        logic              uni_match;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [AGE_W-1:0]  timeout;
    } back_cfg_t;

    typedef struct packed {
        logic [LVL_W-1:0] from_lvl;
        logic [LVL_W-1:0] to_lvl;
        logic [MS_W-1:0]  elapsed;
        logic [MS_W-1:0]  length;
    } blend_req_t;

endpackage

>>> hdl/dmxm_front.sv
// front end: accepts items, classifies them and queues them for the back end
module dmxm_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                hold_off,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dmxm_pkg::IN_DATA_W-1:0]      s_data,
    input  logic                                s_last,
    input  logic [dmxm_pkg::KIND_W-1:0]         s_user,
    input  logic [dmxm_pkg::UNI_W-1:0]          match_addr,
    output logic                                q_valid,
    output dmxm_pkg::item_t                     q_item,
    input  logic                                q_pop
);

    dmxm_pkg::item_t                  queue_reg [dmxm_pkg::QUEUE_DEPTH];
    logic [dmxm_pkg::QUEUE_AW-1:0]    wptr_reg;
    logic [dmxm_pkg::QUEUE_AW-1:0]    rptr_reg;
    logic [dmxm_pkg::QUEUE_AW:0]      count_reg;
    dmxm_pkg::item_t                  in_item;
    logic                             known_kind;
    logic                             accept;
    logic                             push;
    logic                             pop;

    always_comb
    begin
        in_item.kind = dmxm_pkg::kind_t'(s_user);
        in_item.channel = s_data[8:0];
        in_item.level = s_data[16:9];
        in_item.last = s_last;
        in_item.fade_ms = s_data[51:32];
        in_item.uni_match = (s_data[31:17] == match_addr);
        case (dmxm_pkg::kind_t'(s_user))
            dmxm_pkg::K_TICK, dmxm_pkg::K_LOCAL, dmxm_pkg::K_NET, dmxm_pkg::K_FILL,
            dmxm_pkg::K_TARGET, dmxm_pkg::K_FADE, dmxm_pkg::K_READ: known_kind = 1'b1;
            default: known_kind = 1'b0;
        endcase
    end

    assign s_ready = !hold_off && (count_reg != (dmxm_pkg::QUEUE_AW+1)'(dmxm_pkg::QUEUE_DEPTH));
    assign accept = s_valid && s_ready;
    // undefined kinds are dropped here
    assign push = accept && known_kind;
    assign q_valid = (count_reg != '0);
    assign pop = q_pop && q_valid;
    assign q_item = queue_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wptr_reg] <= in_item;
    end

endmodule

>>> hdl/dmxm_blend.sv
// crossfade level unit: multiply then restoring divide, one quotient bit a cycle
module dmxm_blend
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  dmxm_pkg::blend_req_t          req,
    output logic                          done,
    output logic [dmxm_pkg::LVL_W-1:0]    level
);

    logic                               busy_reg;
    logic [3:0]                         step_reg;
    logic                               done_reg;
    logic [dmxm_pkg::LVL_W-1:0]         from_reg;
    logic                               neg_reg;
    logic [dmxm_pkg::LVL_W-1:0]         mag_reg;
    logic [dmxm_pkg::MS_W-1:0]          elap_reg;
    logic [dmxm_pkg::PROD_W-1:0]        div_reg;
    logic [dmxm_pkg::PROD_W-1:0]        rem_reg;
    logic [dmxm_pkg::LVL_W-1:0]         q_reg;
    logic [dmxm_pkg::LVL_W-1:0]         level_reg;

    assign done = done_reg;
    assign level = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == dmxm_pkg::BLEND_LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            from_reg <= req.from_lvl;
            neg_reg <= (req.to_lvl < req.from_lvl);
            mag_reg <= (req.to_lvl < req.from_lvl) ? (req.from_lvl - req.to_lvl)
                                                   : (req.to_lvl - req.from_lvl);
            elap_reg <= req.elapsed;
            div_reg <= dmxm_pkg::PROD_W'(req.length) << (dmxm_pkg::LVL_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                rem_reg <= dmxm_pkg::PROD_W'(mag_reg) * dmxm_pkg::PROD_W'(elap_reg);
                q_reg <= '0;
            end
            else if (step_reg == dmxm_pkg::BLEND_LAST_STEP)
                level_reg <= neg_reg ? (from_reg - q_reg) : (from_reg + q_reg);
            else
            begin
                // quotient always fits the level width since elapsed < length
                if (rem_reg >= div_reg)
                begin
                    rem_reg <= rem_reg - div_reg;
                    q_reg <= {q_reg[dmxm_pkg::LVL_W-2:0], 1'b1};
                end
                else
                    q_reg <= {q_reg[dmxm_pkg::LVL_W-2:0], 1'b0};
                div_reg <= div_reg >> 1;
            end
        end
    end

endmodule

>>> hdl/dmxm_back.sv
// back end: layer memories, sequencer for sweeps, merge and result register
module dmxm_back
#(
    parameter int CHANNEL_COUNT = dmxm_pkg::DEFAULT_CHANNEL_COUNT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dmxm_pkg::back_cfg_t                 cfg,
    output logic                                clearing,
    input  logic                                q_valid,
    input  dmxm_pkg::item_t                     q_item,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dmxm_pkg::OUT_DATA_W-1:0]     m_data
);

    localparam int AW = $clog2(CHANNEL_COUNT);
    localparam logic [AW-1:0] LAST_IDX = AW'(CHANNEL_COUNT - 1);
    localparam logic [dmxm_pkg::CH_W:0] CH_LIMIT = (dmxm_pkg::CH_W+1)'(CHANNEL_COUNT);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_RD_PUSH,
        ST_FILL,
        ST_NCLR,
        ST_XFER_RD,
        ST_XFER_WR,
        ST_BL_RD,
        ST_BL_GO,
        ST_BL_WAIT
    } state_t;

    state_t                         state_reg;
    logic [AW-1:0]                  idx_reg;
    logic                           fade_on_reg;
    logic [dmxm_pkg::MS_W-1:0]      elapsed_reg;
    logic [dmxm_pkg::MS_W-1:0]      length_reg;
    logic                           seen_reg;
    logic [dmxm_pkg::AGE_W-1:0]     age_reg;
    logic                           act_reg;
    logic                           snap_reg;
    logic                           cur_in_range_reg;
    logic                           out_valid_reg;
    logic [dmxm_pkg::CH_W-1:0]      cur_ch_reg;
    logic [dmxm_pkg::LVL_W-1:0]     cur_lvl_reg;
    logic [dmxm_pkg::LVL_W-1:0]     res_lvl_reg;
    logic [dmxm_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [dmxm_pkg::LVL_W-1:0] local_mem [CHANNEL_COUNT];
    logic [dmxm_pkg::LVL_W-1:0] net_mem [CHANNEL_COUNT];
    logic [dmxm_pkg::LVL_W-1:0] hold_mem [CHANNEL_COUNT];
    logic [dmxm_pkg::LVL_W-1:0] start_mem [CHANNEL_COUNT];
    logic [dmxm_pkg::LVL_W-1:0] target_mem [CHANNEL_COUNT];

    logic local_we, net_we, hold_we, start_we, target_we;
    logic [AW-1:0] local_wa, net_wa, hold_wa, start_wa, target_wa;
    logic [dmxm_pkg::LVL_W-1:0] local_wd, net_wd, hold_wd, start_wd, target_wd;
    logic [AW-1:0] local_ra, net_ra, hold_ra, start_ra, target_ra;
    logic [dmxm_pkg::LVL_W-1:0] local_rd, net_rd, hold_rd, start_rd, target_rd;

    logic                           head_in;
    logic [AW-1:0]                  head_idx;
    logic [AW-1:0]                  cur_idx;
    logic [dmxm_pkg::CH_W:0]        nclr_start;
    logic [dmxm_pkg::MS_W-1:0]      elapsed_inc;
    logic [dmxm_pkg::LVL_W-1:0]     merged;
    logic [dmxm_pkg::LVL_W-1:0]     mode_lvl;
    logic                           out_push;
    logic                           blend_start;
    logic                           blend_done;
    logic [dmxm_pkg::LVL_W-1:0]     blend_lvl;
    dmxm_pkg::blend_req_t           blend_req;

    dmxm_blend u_blend
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (blend_start),
        .req   (blend_req),
        .done  (blend_done),
        .level (blend_lvl)
    );

    assign head_in = ({1'b0, q_item.channel} < CH_LIMIT);
    assign head_idx = q_item.channel[AW-1:0];
    assign cur_idx = cur_ch_reg[AW-1:0];
    assign nclr_start = {1'b0, q_item.channel} + 1'b1;
    assign elapsed_inc = (elapsed_reg != dmxm_pkg::ELAPSED_MAX) ? elapsed_reg + 1'b1
                                                                 : elapsed_reg;
    assign out_push = (state_reg == ST_RD_PUSH) && (!out_valid_reg || m_ready);
    assign clearing = (state_reg == ST_CLEAR);
    assign m_valid = out_valid_reg;
    assign m_data = out_data_reg;

    assign blend_req.from_lvl = start_rd;
    assign blend_req.to_lvl = target_rd;
    assign blend_req.elapsed = elapsed_reg;
    assign blend_req.length = length_reg;

    // merge by mode, undefined mode behaves as highest takes precedence
    always_comb
    begin
        case (cfg.mode)
            dmxm_pkg::MODE_LOCAL: mode_lvl = local_rd;
            dmxm_pkg::MODE_NET_HOLD: mode_lvl = act_reg ? net_rd : hold_rd;
            default: mode_lvl = (act_reg && (net_rd > local_rd)) ? net_rd : local_rd;
        endcase
        merged = cur_in_range_reg ? mode_lvl : '0;
    end

    always_comb
    begin
        local_we = 1'b0;
        net_we = 1'b0;
        hold_we = 1'b0;
        start_we = 1'b0;
        target_we = 1'b0;
        local_wa = idx_reg;
        net_wa = idx_reg;
        hold_wa = idx_reg;
        start_wa = idx_reg;
        target_wa = idx_reg;
        local_wd = '0;
        net_wd = '0;
        hold_wd = '0;
        start_wd = '0;
        target_wd = '0;
        local_ra = cur_idx;
        net_ra = cur_idx;
        hold_ra = cur_idx;
        start_ra = idx_reg;
        target_ra = idx_reg;
        q_pop = 1'b0;
        blend_start = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                local_we = 1'b1;
                net_we = 1'b1;
                hold_we = 1'b1;
                target_we = 1'b1;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        dmxm_pkg::K_LOCAL:
                        begin
                            local_we = !fade_on_reg && head_in;
                            local_wa = head_idx;
                            local_wd = q_item.level;
                        end
                        dmxm_pkg::K_NET:
                        begin
                            net_we = q_item.uni_match && head_in;
                            net_wa = head_idx;
                            net_wd = q_item.level;
                        end
                        dmxm_pkg::K_TARGET:
                        begin
                            target_we = head_in;
                            target_wa = head_idx;
                            target_wd = q_item.level;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_DATA:
            begin
                hold_we = cur_in_range_reg;
                hold_wa = cur_idx;
                hold_wd = merged;
            end
            ST_FILL:
            begin
                local_we = 1'b1;
                local_wd = cur_lvl_reg;
            end
            ST_NCLR:
            begin
                net_we = 1'b1;
            end
            ST_XFER_RD:
            begin
                local_ra = idx_reg;
            end
            ST_XFER_WR:
            begin
                if (snap_reg)
                begin
                    start_we = 1'b1;
                    start_wd = local_rd;
                end
                else
                begin
                    local_we = 1'b1;
                    local_wd = target_rd;
                end
            end
            ST_BL_GO:
            begin
                blend_start = 1'b1;
            end
            ST_BL_WAIT:
            begin
                local_we = blend_done;
                local_wd = blend_lvl;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (local_we)
            local_mem[local_wa] <= local_wd;
        local_rd <= local_mem[local_ra];
    end

    always_ff @(posedge clk)
    begin
        if (net_we)
            net_mem[net_wa] <= net_wd;
        net_rd <= net_mem[net_ra];
    end

    always_ff @(posedge clk)
    begin
        if (hold_we)
            hold_mem[hold_wa] <= hold_wd;
        hold_rd <= hold_mem[hold_ra];
    end

    always_ff @(posedge clk)
    begin
        if (start_we)
            start_mem[start_wa] <= start_wd;
        start_rd <= start_mem[start_ra];
    end

    always_ff @(posedge clk)
    begin
        if (target_we)
            target_mem[target_wa] <= target_wd;
        target_rd <= target_mem[target_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg <= '0;
            fade_on_reg <= 1'b0;
            elapsed_reg <= '0;
            length_reg <= dmxm_pkg::DEFAULT_FADE_LENGTH;
            seen_reg <= 1'b0;
            age_reg <= '0;
            act_reg <= 1'b0;
            snap_reg <= 1'b0;
            cur_in_range_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        case (q_item.kind)
                            dmxm_pkg::K_TICK:
                            begin
                                if (age_reg != dmxm_pkg::AGE_MAX)
                                    age_reg <= age_reg + 1'b1;
                                if (fade_on_reg)
                                begin
                                    elapsed_reg <= elapsed_inc;
                                    idx_reg <= '0;
                                    if (elapsed_inc >= length_reg)
                                    begin
                                        // fade done: targets land in the local layer
                                        fade_on_reg <= 1'b0;
                                        snap_reg <= 1'b0;
                                        state_reg <= ST_XFER_RD;
                                    end
                                    else
                                        state_reg <= ST_BL_RD;
                                end
                            end
                            dmxm_pkg::K_NET:
                            begin
                                if (q_item.uni_match && q_item.last)
                                begin
                                    age_reg <= '0;
                                    seen_reg <= 1'b1;
                                    if (nclr_start < CH_LIMIT)
                                    begin
                                        idx_reg <= nclr_start[AW-1:0];
                                        state_reg <= ST_NCLR;
                                    end
                                end
                            end
                            dmxm_pkg::K_FILL:
                            begin
                                fade_on_reg <= 1'b0;
                                idx_reg <= '0;
                                state_reg <= ST_FILL;
                            end
                            dmxm_pkg::K_FADE:
                            begin
                                elapsed_reg <= '0;
                                length_reg <= (q_item.fade_ms == '0) ? dmxm_pkg::MS_W'(1)
                                                                     : q_item.fade_ms;
                                fade_on_reg <= 1'b1;
                                snap_reg <= 1'b1;
                                idx_reg <= '0;
                                state_reg <= ST_XFER_RD;
                            end
                            dmxm_pkg::K_READ:
                            begin
                                act_reg <= seen_reg && (age_reg < cfg.timeout);
                                cur_in_range_reg <= head_in;
                                state_reg <= ST_RD_ADDR;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_RD_ADDR:
                    state_reg <= ST_RD_DATA;
                ST_RD_DATA:
                    state_reg <= ST_RD_PUSH;
                ST_RD_PUSH:
                begin
                    if (out_push)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FILL, ST_NCLR:
                begin
                    if (idx_reg == LAST_IDX)
                        state_reg <= ST_IDLE;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_XFER_RD:
                    state_reg <= ST_XFER_WR;
                ST_XFER_WR:
                begin
                    if (idx_reg == LAST_IDX)
                        state_reg <= ST_IDLE;
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= ST_XFER_RD;
                    end
                end
                ST_BL_RD:
                    state_reg <= ST_BL_GO;
                ST_BL_GO:
                    state_reg <= ST_BL_WAIT;
                ST_BL_WAIT:
                begin
                    if (blend_done)
                    begin
                        if (idx_reg == LAST_IDX)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= ST_BL_RD;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && q_valid)
        begin
            cur_ch_reg <= q_item.channel;
            cur_lvl_reg <= q_item.level;
        end
        if (state_reg == ST_RD_DATA)
            res_lvl_reg <= merged;
        if (out_push)
            out_data_reg <= {5'b0, fade_on_reg, act_reg, res_lvl_reg, cur_ch_reg};
    end

endmodule

>>> hdl/dmx_layer_merge_with_crossfade_core.sv
// top level of the dmx layer merge with crossfade block
// Keeps local, network and hold layers of CHANNEL_COUNT 8-bit channels plus a
// crossfade engine, fed by one item stream and read back through result items.
// After reset a clearing pass zeroes the layers; no item is taken during it
// (register writes are). Items then queue in a four-entry queue in front of a
// sequencer that owns five layer memories, each with one write port and one
// read port. A local write, network store, target load or tick without a fade
// is done as the item is taken off the queue; a read also waits on any stall
// of the output; fill all writes every local channel; a fade start or the tick
// that ends a fade copies one layer into another; a last network item clears
// each network channel above it; a tick during a fade recomputes every local
// channel through the shared multiply and divide unit.
module dmx_layer_merge_with_crossfade_core
#(
    parameter int CHANNEL_COUNT = dmxm_pkg::DEFAULT_CHANNEL_COUNT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // item stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // channel[8:0], level[16:9], universe[31:17], fade_ms[51:32], zero fill above
    input  logic [dmxm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // last_of_frame
    input  logic                                s_axis_tlast,
    // kind[2:0]
    input  logic [dmxm_pkg::KIND_W-1:0]         s_axis_tuser,
    // result stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_channel[8:0], out_level[16:9], network_active[17], fade_running[18]
    output logic [dmxm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmxm_pkg::ADDR_W-1:0]         paddr,
    input  logic [dmxm_pkg::REG_W-1:0]          pwdata,
    output logic [dmxm_pkg::REG_W-1:0]          prdata,
    output logic                                pready
);

    logic [dmxm_pkg::MODE_W-1:0]  merge_mode_reg;
    logic [dmxm_pkg::NET_W-1:0]   net_number_reg;
    logic [dmxm_pkg::SUB_W-1:0]   subnet_number_reg;
    logic [dmxm_pkg::UNIN_W-1:0]  universe_number_reg;
    logic [dmxm_pkg::AGE_W-1:0]   timeout_reg;

    logic                         cfg_write;
    logic [2:0]                   reg_index;
    logic                         clearing;
    logic                         q_valid;
    logic                         q_pop;
    dmxm_pkg::item_t              q_item;
    dmxm_pkg::back_cfg_t          back_cfg;
    logic [dmxm_pkg::UNI_W-1:0]   match_addr;

    // registers are word aligned, the low address bits are ignored
    assign pready = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_mode_reg <= dmxm_pkg::MODE_HTP;
            net_number_reg <= '0;
            subnet_number_reg <= '0;
            universe_number_reg <= '0;
            timeout_reg <= dmxm_pkg::DEFAULT_TIMEOUT;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                dmxm_pkg::REG_MERGE_MODE: merge_mode_reg <= pwdata[dmxm_pkg::MODE_W-1:0];
                dmxm_pkg::REG_NET: net_number_reg <= pwdata[dmxm_pkg::NET_W-1:0];
                dmxm_pkg::REG_SUBNET: subnet_number_reg <= pwdata[dmxm_pkg::SUB_W-1:0];
                dmxm_pkg::REG_UNIVERSE: universe_number_reg <= pwdata[dmxm_pkg::UNIN_W-1:0];
                dmxm_pkg::REG_TIMEOUT: timeout_reg <= pwdata[dmxm_pkg::AGE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            dmxm_pkg::REG_MERGE_MODE: prdata = dmxm_pkg::REG_W'(merge_mode_reg);
            dmxm_pkg::REG_NET: prdata = dmxm_pkg::REG_W'(net_number_reg);
            dmxm_pkg::REG_SUBNET: prdata = dmxm_pkg::REG_W'(subnet_number_reg);
            dmxm_pkg::REG_UNIVERSE: prdata = dmxm_pkg::REG_W'(universe_number_reg);
            dmxm_pkg::REG_TIMEOUT: prdata = dmxm_pkg::REG_W'(timeout_reg);
            default: prdata = '0;
        endcase
    end

    // accepted universe: net in the top bits, then subnet, then universe
    assign match_addr = {net_number_reg, subnet_number_reg, universe_number_reg};
    assign back_cfg.mode = merge_mode_reg;
    assign back_cfg.timeout = timeout_reg;

    dmxm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_off   (clearing),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .s_last     (s_axis_tlast),
        .s_user     (s_axis_tuser),
        .match_addr (match_addr),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    dmxm_back #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (back_cfg),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata)
    );

endmodule

>>> hdl/dmxm_checker.sv
// port level checks for the dmx layer merge block, bound to the top level
module dmxm_checker
#(
    parameter int CHANNEL_COUNT = dmxm_pkg::DEFAULT_CHANNEL_COUNT
)
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [dmxm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [dmxm_pkg::ADDR_W-1:0]         paddr,
    input logic [dmxm_pkg::REG_W-1:0]          pwdata,
    input logic [dmxm_pkg::REG_W-1:0]          prdata,
    input logic                                pready
);

    localparam logic [dmxm_pkg::CH_W:0] CH_LIMIT = (dmxm_pkg::CH_W+1)'(CHANNEL_COUNT);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // reading a channel beyond the layer returns zero
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ({1'b0, m_axis_tdata[8:0]} >= CH_LIMIT) |-> m_axis_tdata[16:9] == '0)
        else $error("out of range channel returned a level");

    // merge mode reads back what was written
    a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr == dmxm_pkg::ADDR_MERGE_MODE
        |=> paddr != dmxm_pkg::ADDR_MERGE_MODE || prdata[1:0] == $past(pwdata[1:0]))
        else $error("merge mode readback mismatch");

endmodule

bind dmx_layer_merge_with_crossfade_core dmxm_checker #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_chk (.*);
